@@ rtl/pfb_pkg.sv @@
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // byte width of one column slice of a page
  localparam int DATA_W = 8;
  // coordinate width: covers the widest far edge (x + length + 1) and the largest screen
  localparam int CRD_W  = 11;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LINE  = 2'd1,
    ACT_RECT  = 2'd2,
    ACT_READ  = 2'd3
  } act_t;

  // the edges of a rectangle outline (top, bottom, left, right), drawn in this order
  typedef enum logic [1:0] {
    SEG_TOP    = 2'd0,
    SEG_BOTTOM = 2'd1,
    SEG_LEFT   = 2'd2,
    SEG_RIGHT  = 2'd3
  } seg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_SETUP,
    ST_RUN,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_t;

endpackage

@@ rtl/page_framebuffer_line_rect_engine.sv @@
`timescale 1ns / 1ps

// Channel  | Ports                                                   | Direction
// ---------+---------------------------------------------------------+----------
// in_      | valid, ready, action, x, y, length, height, color,      | command in
//          | vertical, fill, page                                    |
// out_     | valid, ready, read_data, clipped                        | result out
//
// After reset the store is swept to zero, one byte a cycle, with in_ready low. Clear
// sweeps the store the same way. A draw reads, modifies and writes back one touched
// byte per cycle, with a setup step per edge (one edge for a line or filled rectangle,
// four for an outline). A read passes through the read and read-wait states, and skips
// the wait when it falls off the store. A new item is taken while a result waits on
// out_ready; a finished item waits in its last state until the output
// register is free.

module page_framebuffer_line_rect_engine #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [6:0] in_x,
  input  logic [5:0] in_y,
  input  logic [7:0] in_length,
  input  logic [6:0] in_height,
  input  logic       in_color,
  input  logic       in_vertical,
  input  logic       in_fill,
  input  logic [2:0] in_page,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_clipped
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int ROWS  = PAGES * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW    = pfb_pkg::CRD_W;
  localparam int DW    = pfb_pkg::DATA_W;

  localparam logic [CW-1:0] COLS_C = CW'(COLUMNS);
  localparam logic [CW-1:0] ROWS_C = CW'(ROWS);

  pfb_pkg::state_t state_r, state_nxt;

  // command
  pfb_pkg::act_t   cmd_action_r, cmd_action_nxt;
  logic [6:0]      cmd_x_r, cmd_x_nxt;
  logic [5:0]      cmd_y_r, cmd_y_nxt;
  logic [7:0]      cmd_length_r, cmd_length_nxt;
  logic [6:0]      cmd_height_r, cmd_height_nxt;
  logic            cmd_color_r, cmd_color_nxt;
  logic            cmd_vert_r, cmd_vert_nxt;
  logic            cmd_fill_r, cmd_fill_nxt;
  logic [2:0]      cmd_page_r, cmd_page_nxt;

  // walk over one clamped pixel box
  pfb_pkg::seg_t   seg_r, seg_nxt;
  logic [CW-1:0]   c0_r, c0_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   col_end_r, col_end_nxt;
  logic [CW-1:0]   r0_r, r0_nxt;
  logic [CW-1:0]   r_last_r, r_last_nxt;
  logic [PGW-1:0]  pg_r, pg_nxt;
  logic [PGW-1:0]  pg_last_r, pg_last_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;

  // write-back stage
  logic            s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]   s1_addr_r, s1_addr_nxt;
  logic [DW-1:0]   s1_mask_r, s1_mask_nxt;

  logic            clip_r, clip_nxt;
  logic [DW-1:0]   data_r, data_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   out_data_r, out_data_nxt;
  logic            out_clip_r, out_clip_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  // box geometry of the current edge, half-open on both axes
  logic [CW-1:0]   xe, ye, le, he;
  logic [CW-1:0]   g_c0, g_c1, g_r0, g_r1, g_c1c, g_r1c;
  logic            g_clip, g_go, last_seg;
  logic [PGW-1:0]  g_pg;
  logic [2:0]      lo_bit, hi_bit;
  logic [DW-1:0]   run_mask;
  logic            rd_ok;

  pfb_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign xe = CW'(cmd_x_r);
  assign ye = CW'(cmd_y_r);
  assign le = CW'(cmd_length_r);
  assign he = CW'(cmd_height_r);

  always_comb begin
    g_c0 = xe;
    g_c1 = xe + le;
    g_r0 = ye;
    g_r1 = ye + CW'(1);
    if (cmd_action_r == pfb_pkg::ACT_LINE) begin
      if (cmd_vert_r) begin
        g_c1 = xe + CW'(1);
        g_r1 = ye + le;
      end
    end else if (cmd_fill_r) begin
      g_r1 = ye + he + CW'(1);
    end else begin
      unique case (seg_r)
        pfb_pkg::SEG_TOP: begin
        end
        pfb_pkg::SEG_BOTTOM: begin
          g_r0 = ye + he;
          g_r1 = ye + he + CW'(1);
        end
        pfb_pkg::SEG_LEFT: begin
          g_c1 = xe + CW'(1);
          g_r1 = ye + he;
        end
        pfb_pkg::SEG_RIGHT: begin
          g_c0 = xe + le;
          g_c1 = xe + le + CW'(1);
          g_r1 = ye + he;
        end
      endcase
    end
  end

  assign g_c1c    = (g_c1 > COLS_C) ? COLS_C : g_c1;
  assign g_r1c    = (g_r1 > ROWS_C) ? ROWS_C : g_r1;
  assign g_clip   = (g_c1 > g_c0) && (g_r1 > g_r0) && ((g_c1 > COLS_C) || (g_r1 > ROWS_C));
  assign g_go     = (g_c0 < g_c1c) && (g_r0 < g_r1c);
  assign g_pg     = PGW'(g_r0 >> 3);
  assign last_seg = !((cmd_action_r == pfb_pkg::ACT_RECT) && !cmd_fill_r) ||
                    (seg_r == pfb_pkg::SEG_RIGHT);

  // rows of the box that fall in the current page
  assign lo_bit   = (pg_r == PGW'(r0_r >> 3)) ? r0_r[2:0] : 3'd0;
  assign hi_bit   = (pg_r == pg_last_r) ? r_last_r[2:0] : 3'd7;
  assign run_mask = (DW'(8'hFF) << lo_bit) & (DW'(8'hFF) >> (3'd7 - hi_bit));

  assign rd_ok = (CW'(cmd_page_r) < CW'(PAGES)) && (CW'(cmd_x_r) < COLS_C);

  always_comb begin
    state_nxt      = state_r;
    cmd_action_nxt = cmd_action_r;
    cmd_x_nxt      = cmd_x_r;
    cmd_y_nxt      = cmd_y_r;
    cmd_length_nxt = cmd_length_r;
    cmd_height_nxt = cmd_height_r;
    cmd_color_nxt  = cmd_color_r;
    cmd_vert_nxt   = cmd_vert_r;
    cmd_fill_nxt   = cmd_fill_r;
    cmd_page_nxt   = cmd_page_r;
    seg_nxt        = seg_r;
    c0_nxt         = c0_r;
    col_nxt        = col_r;
    col_end_nxt    = col_end_r;
    r0_nxt         = r0_r;
    r_last_nxt     = r_last_r;
    pg_nxt         = pg_r;
    pg_last_nxt    = pg_last_r;
    base_nxt       = base_r;
    clr_nxt        = clr_r;
    clip_nxt       = clip_r;
    data_nxt       = data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_clip_nxt   = out_clip_r;

    ram_raddr   = base_r + AW'(col_r);
    s1_vld_nxt  = 1'b0;
    s1_addr_nxt = ram_raddr;
    s1_mask_nxt = run_mask;

    // read data of the previous cycle is modified and written back here
    ram_we    = s1_vld_r;
    ram_waddr = s1_addr_r;
    ram_wdata = cmd_color_r ? (ram_rdata | s1_mask_r) : (ram_rdata & ~s1_mask_r);

    unique case (state_r)
      pfb_pkg::ST_INIT, pfb_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          clr_nxt   = '0;
          state_nxt = (state_r == pfb_pkg::ST_INIT) ? pfb_pkg::ST_IDLE : pfb_pkg::ST_DONE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_action_nxt = pfb_pkg::act_t'(in_action);
          cmd_x_nxt      = in_x;
          cmd_y_nxt      = in_y;
          cmd_length_nxt = in_length;
          cmd_height_nxt = in_height;
          cmd_color_nxt  = in_color;
          cmd_vert_nxt   = in_vertical;
          cmd_fill_nxt   = in_fill;
          cmd_page_nxt   = in_page;
          seg_nxt        = pfb_pkg::SEG_TOP;
          clip_nxt       = 1'b0;
          data_nxt       = '0;
          unique case (pfb_pkg::act_t'(in_action))
            pfb_pkg::ACT_CLEAR: state_nxt = pfb_pkg::ST_CLR;
            pfb_pkg::ACT_LINE:  state_nxt = pfb_pkg::ST_SETUP;
            pfb_pkg::ACT_RECT:  state_nxt = pfb_pkg::ST_SETUP;
            pfb_pkg::ACT_READ:  state_nxt = pfb_pkg::ST_RD;
          endcase
        end
      end
      pfb_pkg::ST_SETUP: begin
        clip_nxt = clip_r | g_clip;
        if (g_go) begin
          c0_nxt      = g_c0;
          col_nxt     = g_c0;
          col_end_nxt = g_c1c - CW'(1);
          r0_nxt      = g_r0;
          r_last_nxt  = g_r1c - CW'(1);
          pg_nxt      = g_pg;
          pg_last_nxt = PGW'((g_r1c - CW'(1)) >> 3);
          base_nxt    = AW'(int'(g_pg) * COLUMNS);
          state_nxt   = pfb_pkg::ST_RUN;
        end else if (last_seg) begin
          state_nxt = pfb_pkg::ST_DONE;
        end else begin
          seg_nxt = pfb_pkg::seg_t'(seg_r + 2'd1);
        end
      end
      pfb_pkg::ST_RUN: begin
        s1_vld_nxt = 1'b1;
        if (col_r == col_end_r) begin
          if (pg_r == pg_last_r) begin
            // the setup cycle keeps the last write of this edge clear of the next read
            if (last_seg) begin
              state_nxt = pfb_pkg::ST_DONE;
            end else begin
              seg_nxt   = pfb_pkg::seg_t'(seg_r + 2'd1);
              state_nxt = pfb_pkg::ST_SETUP;
            end
          end else begin
            pg_nxt   = pg_r + PGW'(1);
            base_nxt = base_r + AW'(COLUMNS);
            col_nxt  = c0_r;
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      pfb_pkg::ST_RD: begin
        ram_raddr = AW'(int'(cmd_page_r) * COLUMNS + int'(cmd_x_r));
        if (rd_ok) begin
          state_nxt = pfb_pkg::ST_RDW;
        end else begin
          clip_nxt  = 1'b1;
          state_nxt = pfb_pkg::ST_DONE;
        end
      end
      pfb_pkg::ST_RDW: begin
        data_nxt  = ram_rdata;
        state_nxt = pfb_pkg::ST_DONE;
      end
      pfb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_clip_nxt  = clip_r;
          state_nxt     = pfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfb_pkg::ST_INIT;
      clr_r       <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_action_r <= cmd_action_nxt;
    cmd_x_r      <= cmd_x_nxt;
    cmd_y_r      <= cmd_y_nxt;
    cmd_length_r <= cmd_length_nxt;
    cmd_height_r <= cmd_height_nxt;
    cmd_color_r  <= cmd_color_nxt;
    cmd_vert_r   <= cmd_vert_nxt;
    cmd_fill_r   <= cmd_fill_nxt;
    cmd_page_r   <= cmd_page_nxt;
    seg_r        <= seg_nxt;
    c0_r         <= c0_nxt;
    col_r        <= col_nxt;
    col_end_r    <= col_end_nxt;
    r0_r         <= r0_nxt;
    r_last_r     <= r_last_nxt;
    pg_r         <= pg_nxt;
    pg_last_r    <= pg_last_nxt;
    base_r       <= base_nxt;
    s1_addr_r    <= s1_addr_nxt;
    s1_mask_r    <= s1_mask_nxt;
    clip_r       <= clip_nxt;
    data_r       <= data_nxt;
    out_data_r   <= out_data_nxt;
    out_clip_r   <= out_clip_nxt;
  end

  assign in_ready      = (state_r == pfb_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_clipped   = out_clip_r;

endmodule

@@ rtl/pfb_ram.sv @@
`timescale 1ns / 1ps

module pfb_ram #(
  parameter int WIDTH = pfb_pkg::DATA_W,
  parameter int DEPTH = pfb_pkg::COLUMNS_DEF * pfb_pkg::PAGES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
